[hdl/aes_cbc_pkg.sv]
// aes_cbc_pkg: shared types, constants and byte-level functions for the aes-128 cbc block
// no dependencies

package aes_cbc_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ROUNDS = 10;
    localparam int ROUND_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;

    typedef struct packed {
        logic [HALF_W-1:0] block_high;
        logic [HALF_W-1:0] block_low;
        logic              first_block;
    } in_beat_t;

    typedef struct packed {
        logic [HALF_W-1:0] result_high;
        logic [HALF_W-1:0] result_low;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_DONE
    } state_t;

    // control from sequencer to round unit
    typedef struct packed {
        logic               load;
        logic               step;
        logic               decrypt;
        logic [ROUND_W-1:0] round;
    } round_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 in top bits
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // forward round constant for round r (1..10)
    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[hdl/aes_cbc_key.sv]
// aes_cbc_key: round key generator, one round key per step, forward or backward
// depends on aes_cbc_pkg

module aes_cbc_key
    import aes_cbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,      // load cipher key as round key 0
    input  logic [BLOCK_W-1:0]   key_in,
    input  logic                 fwd_step,  // round key r-1 -> r
    input  logic                 bwd_step,  // round key r -> r-1
    input  logic [ROUND_W-1:0]   round,     // r for the step
    output logic [BLOCK_W-1:0]   key_out
);

    logic [BLOCK_W-1:0] key_reg, key_next;
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3, p0, p1, p2, p3;

    function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
        return {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    endfunction

    // forward and backward schedule words
    always_comb begin
        {w0, w1, w2, w3} = key_reg;
        n0 = w0 ^ sub_rot(w3, rcon(round));
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        p3 = w3 ^ w2;
        p2 = w2 ^ w1;
        p1 = w1 ^ w0;
        t  = sub_rot(p3, rcon(round));
        p0 = w0 ^ t;
        key_next = key_reg;
        if (load) begin
            key_next = key_in;
        end else if (fwd_step) begin
            key_next = {n0, n1, n2, n3};
        end else if (bwd_step) begin
            key_next = {p0, p1, p2, p3};
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

    a_no_dual_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fwd_step && bwd_step)) else $error("key steps both directions");
    a_load_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !(fwd_step || bwd_step)) else $error("key load with step");
    a_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> key_reg == $past(key_in)) else $error("key load lost");

endmodule

[hdl/aes_cbc_round.sv]
// aes_cbc_round: shared round unit for encrypt and decrypt with state register
// depends on aes_cbc_pkg

module aes_cbc_round
    import aes_cbc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  round_ctl_t         ctl,
    input  logic [BLOCK_W-1:0] load_data,
    input  logic [BLOCK_W-1:0] round_key,
    output logic [BLOCK_W-1:0] state_out
);

    logic [BLOCK_W-1:0] st_reg, st_next, sub, shf, mixd, enc, dec, dsb;

    // forward mix of one column
    function automatic logic [31:0] mix_fwd(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        {a0, a1, a2, a3} = c;
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix: premultiply then forward mix
    function automatic logic [31:0] mix_inv(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        {a0, a1, a2, a3} = c;
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    always_comb begin
        // encrypt round: sub, shift, mix (not last), add key
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shf[127-8*(4*c+r) -: 8] = sbox(get_byte(st_reg, 4*((c+r)%4)+r));
                dsb[127-8*(4*c+r) -: 8] = inv_sbox(get_byte(st_reg, 4*((c-r+4)%4)+r));
            end
        end
        for (int c = 0; c < 4; c++) begin
            mixd[127-32*c -: 32] = mix_fwd(shf[127-32*c -: 32]);
        end
        enc = ((ctl.round == ROUND_W'(NUM_ROUNDS)) ? shf : mixd) ^ round_key;
        // decrypt round: inv shift, inv sub, add key, inv mix (not round 0)
        sub = dsb ^ round_key;
        for (int c = 0; c < 4; c++) begin
            dec[127-32*c -: 32] = mix_inv(sub[127-32*c -: 32]);
        end
        if (ctl.round == '0) begin
            dec = sub;
        end
        st_next = st_reg;
        if (ctl.load) begin
            st_next = load_data ^ round_key;
        end else if (ctl.step) begin
            st_next = ctl.decrypt ? dec : enc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

    assign state_out = st_reg;

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.load && ctl.step)) else $error("load and step together");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(ctl.load) && !$past(ctl.step) |-> $stable(st_reg))
        else $error("state moved while idle");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step |-> ctl.round <= ROUND_W'(NUM_ROUNDS)) else $error("round out of range");

endmodule

[hdl/aes128_cbc_cipher.sv]
// aes128_cbc_cipher: top level, configuration registers, cbc chaining and sequencer
// depends on aes_cbc_pkg, aes_cbc_key, aes_cbc_round
//
// usage:
//   s_ channel carries one 128-bit block per beat (two 64-bit halves, byte 0 in top bits)
//   plus first_block, which reloads the chaining value from the iv registers.
//   m_ channel returns one result block per input beat, in order.
//   cfg_we/cfg_idx/cfg_data write key, iv and mode; write only while idle.
// sequence:
//   encrypt: key load, then the initial key add and each cipher round in turn
//   decrypt: key load, key schedule run forward to the last key, then inverse rounds
//   one block at a time; the single round unit sets the rate, s_ready is low meanwhile
// reset:
//   synchronous active-low aresetn clears config registers, state, chaining value and handshake.
// stall:
//   a finished result sits in the output register until m_ready; the next block may
//   be taken meanwhile, but its result waits in the done state until that one has gone.

module aes128_cbc_cipher
    import aes_cbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [HALF_W-1:0]     cfg_data
);

    logic [HALF_W-1:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic              mode_reg;
    logic [BLOCK_W-1:0] chain_reg, chain_next, blk_reg, blk_next;
    logic              dec_reg, dec_next;
    state_t            state_reg, state_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [BLOCK_W-1:0] res_reg, res_next;
    logic              mval_reg, mval_next;
    logic [BLOCK_W-1:0] round_key, st;
    logic              k_load, k_fwd, k_bwd;
    logic [ROUND_W-1:0] k_round;
    round_ctl_t        rctl;
    logic              accept;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                REG_MODE:     mode_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    aes_cbc_key u_key (
        .aclk(aclk), .aresetn(aresetn), .load(k_load),
        .key_in({key_high_reg, key_low_reg}),
        .fwd_step(k_fwd), .bwd_step(k_bwd), .round(k_round), .key_out(round_key)
    );

    aes_cbc_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctl(rctl), .load_data(blk_reg),
        .round_key(round_key), .state_out(st)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        blk_next   = blk_reg;
        dec_next   = dec_reg;
        res_next   = res_reg;
        mval_next  = mval_reg && !m_ready;
        k_load = 1'b0; k_fwd = 1'b0; k_bwd = 1'b0; k_round = rnd_reg;
        rctl = '{load: 1'b0, step: 1'b0, decrypt: dec_reg, round: rnd_reg};
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    k_load   = 1'b1;
                    dec_next = mode_reg;
                    if (s_data.first_block) chain_next = {iv_high_reg, iv_low_reg};
                    if (mode_reg) begin
                        blk_next = {s_data.block_high, s_data.block_low};
                        rnd_next = ROUND_W'(1);
                        state_next = ST_KEY;
                    end else begin
                        blk_next = {s_data.block_high, s_data.block_low} ^
                                   (s_data.first_block ? {iv_high_reg, iv_low_reg} : chain_reg);
                        rnd_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_KEY: begin
                // run schedule forward to the last round key
                k_fwd = 1'b1;
                if (rnd_reg == ROUND_W'(NUM_ROUNDS)) begin
                    rnd_next = '0;
                    state_next = ST_RUN;
                end else begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_RUN: begin
                if (rnd_reg == '0) begin
                    rctl.load = 1'b1;
                    if (dec_reg) begin
                        k_bwd = 1'b1; k_round = ROUND_W'(NUM_ROUNDS);
                        rnd_next = ROUND_W'(NUM_ROUNDS - 1);
                    end else begin
                        k_fwd = 1'b1; k_round = ROUND_W'(1);
                        rnd_next = ROUND_W'(1);
                    end
                end else begin
                    rctl.step = 1'b1;
                    if (dec_reg) begin
                        k_bwd = 1'b1;
                        if (rnd_reg == ROUND_W'(1)) begin
                            // last decrypt round is round 0 without mix, marked by NUM_ROUNDS + 1
                            rnd_next = ROUND_W'(NUM_ROUNDS + 1);
                        end else begin
                            rnd_next = rnd_reg - 1'b1;
                        end
                    end else begin
                        k_fwd = 1'b1; k_round = rnd_reg + 1'b1;
                        if (rnd_reg == ROUND_W'(NUM_ROUNDS)) state_next = ST_DONE;
                        rnd_next = rnd_reg + 1'b1;
                    end
                end
                if (dec_reg && rnd_reg == ROUND_W'(NUM_ROUNDS + 1)) begin
                    // round 0 of decrypt: add key 0, no mix
                    rctl.step = 1'b1; rctl.round = '0;
                    k_bwd = 1'b0;
                    state_next = ST_DONE;
                end else if (dec_reg && rnd_reg != '0) begin
                    k_round = rnd_reg;
                end
            end
            ST_DONE: begin
                // wait here while the previous result is still held
                if (!mval_reg || m_ready) begin
                    if (dec_reg) begin
                        res_next   = st ^ chain_reg;
                        chain_next = blk_reg;
                    end else begin
                        res_next   = st;
                        chain_next = st;
                    end
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            chain_reg <= '0;
            mval_reg  <= 1'b0;
            dec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
            mval_reg  <= mval_next;
            dec_reg   <= dec_next;
        end
        blk_reg <= blk_next;
        res_reg <= res_next;
    end

    assign m_valid = mval_reg;
    assign m_data  = '{result_high: res_reg[127:64], result_low: res_reg[63:0]};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> m_valid) else $error("result not shown");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(res_reg)) else $error("result dropped");
    a_idle_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_KEY) |=> $stable(chain_reg))
        else $error("chain moved mid block");

endmodule

[sim/tb_aes128_cbc_cipher.sv]
// tb_aes128_cbc_cipher: self-checking bench for the aes-128 cbc block, own cipher predictor
// depends on aes_cbc_pkg and aes128_cbc_cipher

module tb_aes128_cbc_cipher;
    timeunit 1ns;
    timeprecision 1ps;
    import aes_cbc_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_beat_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_beat_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [HALF_W-1:0]    cfg_data;

    aes128_cbc_cipher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // predictor copy of registers and chaining value
    logic [127:0] key_q, iv_q, chain_q;
    logic         dec_q;
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [7:0]   rkeys [176];

    out_beat_t    expected_q [$];
    int           mismatches;
    bit           failed;
    bit           stim_done;
    logic [127:0] forced_q [$];   // typed-in expected values, 'x when none
    bit           forced_on_q [$];

    // directed rows
    typedef struct {
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic         first;
        bit           known;
        logic [127:0] ref_out;
    } row_t;
    row_t dir_rows [$];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // builds the forward table from the field inverse and affine map, and the inverse table from it
    task automatic build_tables();
        logic [7:0] inv, b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tab[x] = b;
        end
        for (int x = 0; x < 256; x++) inv_tab[fwd_tab[x]] = x[7:0];
    endtask

    task automatic expand_schedule();
        logic [7:0] t [4];
        logic [7:0] f, rc;
        for (int i = 0; i < 16; i++) rkeys[i] = key_q[127-8*i -: 8];
        rc = 8'h01;
        for (int n = 16; n < 176; n += 4) begin
            for (int i = 0; i < 4; i++) t[i] = rkeys[n-4+i];
            if ((n % 16) == 0) begin
                f = t[0];
                t[0] = fwd_tab[t[1]] ^ rc;
                t[1] = fwd_tab[t[2]];
                t[2] = fwd_tab[t[3]];
                t[3] = fwd_tab[f];
                rc = gmul(rc, 8'h02);
            end
            for (int i = 0; i < 4; i++) rkeys[n+i] = rkeys[n-16+i] ^ t[i];
        end
    endtask

    function automatic logic [127:0] xor_round_key(input logic [127:0] s, input int r);
        for (int i = 0; i < 16; i++) s[127-8*i -: 8] ^= rkeys[16*r+i];
        return s;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input bit fwd);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = fwd ? ((c + r) % 4) : ((c - r + 4) % 4);
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit fwd);
        logic [7:0] k [4];
        logic [7:0] a [4];
        logic [127:0] o;
        if (fwd) k = '{8'h02, 8'h03, 8'h01, 8'h01};
        else     k = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) a[i] = s[127-8*(4*c+i) -: 8];
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = gmul(a[0], k[(4-r)%4]) ^ gmul(a[1], k[(5-r)%4])
                                      ^ gmul(a[2], k[(6-r)%4]) ^ gmul(a[3], k[(7-r)%4]);
        end
        return o;
    endfunction

    function automatic logic [127:0] sub_all(input logic [127:0] s, input bit fwd);
        for (int i = 0; i < 16; i++)
            s[127-8*i -: 8] = fwd ? fwd_tab[s[127-8*i -: 8]] : inv_tab[s[127-8*i -: 8]];
        return s;
    endfunction

    // cbc step: returns the result block and advances the chaining value
    task automatic cbc_step(input in_beat_t b, output logic [127:0] res);
        logic [127:0] s, blk;
        blk = {b.block_high, b.block_low};
        if (b.first_block) chain_q = iv_q;
        expand_schedule();
        if (dec_q) begin
            s = xor_round_key(blk, 10);
            for (int r = 9; r >= 0; r--) begin
                s = sub_all(shift_rows(s, 1'b0), 1'b0);
                s = xor_round_key(s, r);
                if (r != 0) s = mix_cols(s, 1'b0);
            end
            res = s ^ chain_q;
            chain_q = blk;
        end else begin
            s = xor_round_key(blk ^ chain_q, 0);
            for (int r = 1; r <= 10; r++) begin
                s = shift_rows(sub_all(s, 1'b1), 1'b1);
                if (r != 10) s = mix_cols(s, 1'b1);
                s = xor_round_key(s, r);
            end
            res = s;
            chain_q = s;
        end
    endtask

    task automatic add_row(input logic [63:0] hi, input logic [63:0] lo, input logic first,
                           input bit known, input logic [127:0] ref_out);
        row_t r;
        r.hi = hi;
        r.lo = lo;
        r.first = first;
        r.known = known;
        r.ref_out = ref_out;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_KEY_HIGH: key_q[127:64] = val;
            REG_KEY_LOW:  key_q[63:0]   = val;
            REG_IV_HIGH:  iv_q[127:64]  = val;
            REG_IV_LOW:   iv_q[63:0]    = val;
            REG_MODE:     dec_q         = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 94) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // valid stays up after the beat; the next send, a gap or a drain decides its level
    task automatic send_block(input in_beat_t b, input bit known, input logic [127:0] kval);
        logic [127:0] res;
        out_beat_t e;
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        cbc_step(b, res);
        e.result_high = res[127:64];
        e.result_low  = res[63:0];
        expected_q.insert(expected_q.size(), e);
        forced_on_q.insert(forced_on_q.size(), known);
        forced_q.insert(forced_q.size(), kval);
    endtask

    // result checker
    initial begin
        out_beat_t e;
        logic [127:0] kv;
        bit kon;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", m_data);
                end else begin
                    e = expected_q.pop_front();
                    kon = forced_on_q.pop_front();
                    kv = forced_q.pop_front();
                    if (kon && kv != {e.result_high, e.result_low}) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("predictor disagrees with table: exp %h pred %h", kv,
                                     {e.result_high, e.result_low});
                    end
                    if (m_data.result_high !== e.result_high ||
                        m_data.result_low !== e.result_low) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp %h_%h got %h_%h",
                                     e.result_high, e.result_low,
                                     m_data.result_high, m_data.result_low);
                    end
                end
            end
            // receiver stalls, sometimes long, sometimes none
            if (stim_done && $urandom_range(0, 3) != 0) m_ready <= 1'b1;
            else begin
                case ($urandom_range(0, 19))
                    0:       m_ready <= 1'b0;
                    1, 2, 3: m_ready <= ~m_ready;
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        in_beat_t b;
        int n_sent;
        logic [63:0] rnd_hi, rnd_lo;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_KEY_HIGH;
        cfg_data = '0;
        key_q = '0; iv_q = '0; chain_q = '0; dec_q = 1'b0;
        failed = 1'b0; mismatches = 0; stim_done = 1'b0;
        build_tables();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero key and iv, chaining starts from zero; the third block sets first_block
        add_row(64'h0, 64'h0, 1'b0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_row(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 1'b0, 'x);
        add_row(64'h0, 64'h0, 1'b1, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_row(64'h8000000000000000, 64'h1, 1'b0, 1'b0, 'x);
        foreach (dir_rows[i]) begin
            b = '{dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].first};
            send_block(b, dir_rows[i].known, dir_rows[i].ref_out);
        end
        wait_drained();

        // standard test vector key, iv all ones, out-of-range index ignored
        reg_write(REG_KEY_HIGH, 64'h000102030405060 << 4 | 64'h7);
        reg_write(REG_KEY_HIGH, 64'h0001020304050607);
        reg_write(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        reg_write(REG_IV_HIGH,  64'hffffffffffffffff);
        reg_write(REG_IV_LOW,   64'hffffffffffffffff);
        reg_write(3'd7, 64'hdeadbeefdeadbeef);
        reg_write(3'd5, 64'h1);
        dir_rows.delete();
        add_row(64'h0011223344556677 ^ 64'hffffffffffffffff,
                64'h8899aabbccddeeff ^ 64'hffffffffffffffff, 1'b1, 1'b1,
                128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_row(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, 'x);
        add_row(64'h0, 64'hffffffffffffffff, 1'b0, 1'b0, 'x);
        foreach (dir_rows[i]) begin
            b = '{dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].first};
            send_block(b, dir_rows[i].known, dir_rows[i].ref_out);
        end
        wait_drained();

        // decrypt the known ciphertext, then mode value with wide bits
        reg_write(REG_IV_HIGH, 64'h0);
        reg_write(REG_IV_LOW,  64'h0);
        reg_write(REG_MODE,    64'h1);
        b = '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1};
        send_block(b, 1'b1, 128'h00112233445566778899aabbccddeeff);
        b = '{64'hffffffffffffffff, 64'h0, 1'b0};
        send_block(b, 1'b0, 'x);
        wait_drained();
        reg_write(REG_MODE, 64'hfffffffffffffffe);
        b = '{64'h1, 64'h8000000000000000, 1'b0};
        send_block(b, 1'b0, 'x);
        wait_drained();

        // random phases: messages with random content between register changes
        n_sent = 0;
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin
                    reg_write(REG_KEY_HIGH, {$urandom, $urandom});
                    reg_write(REG_KEY_LOW,  {$urandom, $urandom});
                end
                1: begin
                    reg_write(REG_KEY_HIGH, 64'hffffffffffffffff);
                    reg_write(REG_KEY_LOW,  64'hffffffffffffffff);
                end
                2: begin
                    reg_write(REG_KEY_HIGH, 64'h0);
                    reg_write(REG_KEY_LOW,  {$urandom, $urandom});
                end
                default: reg_write(REG_KEY_LOW, {$urandom, $urandom});
            endcase
            reg_write(REG_IV_HIGH, (ph == 5) ? 64'hffffffffffffffff : {$urandom, $urandom});
            reg_write(REG_IV_LOW,  (ph == 6) ? 64'h0 : {$urandom, $urandom});
            reg_write(REG_MODE, {$urandom, $urandom});
            for (int k = 0; k < 100; k++) begin
                rnd_hi = {$urandom, $urandom};
                rnd_lo = {$urandom, $urandom};
                if ($urandom_range(0, 15) == 0) rnd_hi = '0;
                if ($urandom_range(0, 15) == 0) rnd_lo = '1;
                b = '{rnd_hi, rnd_lo, ($urandom_range(0, 9) == 0) || (k == 0)};
                send_block(b, 1'b0, 'x);
                n_sent++;
                if (k == 50) wait_drained();
                else if (!(ph % 5 == 3)) idle_gap();
            end
            wait_drained();
        end
        stim_done = 1'b1;

        wait_drained();
        if (!failed && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
